// File: rtl/core/snfcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer package
// Shared codes, result type and header byte helpers.
// ----------------------------------------------------------------------------
package snfcs_pkg;

  // Page size of the flash; must be a power of two.
  localparam int PAGE_BYTES = 256;
  localparam int PAGE_BITS  = $clog2(PAGE_BYTES);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Request kinds.
  localparam logic [1:0] REQ_OP    = 2'd0;
  localparam logic [1:0] REQ_HOST  = 2'd1;
  localparam logic [1:0] REQ_REPLY = 2'd2;

  // Operations.
  localparam logic [2:0] OP_ID     = 3'd0;
  localparam logic [2:0] OP_READ   = 3'd1;
  localparam logic [2:0] OP_PROG   = 3'd2;
  localparam logic [2:0] OP_SECTOR = 3'd3;
  localparam logic [2:0] OP_HALF   = 3'd4;
  localparam logic [2:0] OP_BLOCK  = 3'd5;
  localparam logic [2:0] OP_CHIP   = 3'd6;

  // Result kinds.
  localparam logic [1:0] KIND_SPI  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_ID   = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  // Flash command bytes.
  localparam logic [7:0] CMD_ID     = 8'h90;
  localparam logic [7:0] CMD_READ   = 8'h03;
  localparam logic [7:0] CMD_PROG   = 8'h02;
  localparam logic [7:0] CMD_SECTOR = 8'h20;
  localparam logic [7:0] CMD_HALF   = 8'h52;
  localparam logic [7:0] CMD_BLOCK  = 8'hd8;
  localparam logic [7:0] CMD_CHIP   = 8'hc7;
  localparam logic [7:0] CMD_WREN   = 8'h06;
  localparam logic [7:0] CMD_RDSR   = 8'h05;
  localparam logic [7:0] DUMMY_BYTE = 8'hFF;
  localparam logic [7:0] STAT_BUSY  = 8'h01;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  spi_byte;
    logic        cs_release;
    logic [15:0] host_value;
    logic        last;
  } res_t;

  typedef enum logic [9:0] {
    PH_IDLE      = 10'b00_0000_0001,
    PH_WREN      = 10'b00_0000_0010,
    PH_PRE_CMD   = 10'b00_0000_0100,
    PH_PRE_STAT  = 10'b00_0000_1000,
    PH_HDR       = 10'b00_0001_0000,
    PH_WAIT_HOST = 10'b00_0010_0000,
    PH_DATA      = 10'b00_0100_0000,
    PH_READ      = 10'b00_1000_0000,
    PH_POST_CMD  = 10'b01_0000_0000,
    PH_POST_STAT = 10'b10_0000_0000
  } phase_t;

  function automatic logic [7:0] opcode_of(input logic [2:0] op);
    logic [7:0] b;
    unique case (op)
      OP_ID:     b = CMD_ID;
      OP_READ:   b = CMD_READ;
      OP_PROG:   b = CMD_PROG;
      OP_SECTOR: b = CMD_SECTOR;
      OP_HALF:   b = CMD_HALF;
      OP_BLOCK:  b = CMD_BLOCK;
      OP_CHIP:   b = CMD_CHIP;
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] last_hdr_frame(input logic [2:0] op);
    logic [2:0] f;
    if (op == OP_ID) f = 3'd5;
    else if (op == OP_CHIP) f = 3'd0;
    else f = 3'd3;
    return f;
  endfunction

  // Builds the SPI beat for one header frame: opcode, address, dummy or id bytes.
  function automatic res_t hdr_res(input logic [2:0] op, input logic [2:0] f,
                                   input logic [23:0] addr, input logic [15:0] left);
    res_t r;
    r = '0;
    r.out_kind = KIND_SPI;
    if (f == 3'd0) r.spi_byte = opcode_of(op);
    else if (f >= 3'd4) r.spi_byte = DUMMY_BYTE;
    else if (op == OP_ID) r.spi_byte = 8'h00;
    else begin
      case (f)
        3'd1:    r.spi_byte = addr[23:16];
        3'd2:    r.spi_byte = addr[15:8];
        default: r.spi_byte = addr[7:0];
      endcase
    end
    r.cs_release = ((op == OP_ID) && (f == 3'd5)) ||
                   ((op == OP_READ) && (f == 3'd3) && (left == 16'd0)) ||
                   ((op >= OP_SECTOR) && (f == last_hdr_frame(op)));
    return r;
  endfunction

  function automatic res_t spi_res(input logic [7:0] b, input logic cs);
    res_t r;
    r = '0;
    r.out_kind   = KIND_SPI;
    r.spi_byte   = b;
    r.cs_release = cs;
    return r;
  endfunction

  function automatic res_t host_res(input logic [1:0] kind, input logic [15:0] v);
    res_t r;
    r = '0;
    r.out_kind   = kind;
    r.host_value = v;
    return r;
  endfunction

endpackage

// File: rtl/core/snfcs_if.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer channels
// Valid/ready interfaces for the request channel and the result channel.
// ----------------------------------------------------------------------------
interface snfcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  op;
  logic [23:0] address;
  logic [15:0] length;
  logic [7:0]  data_byte;

  modport source (output valid, req_type, op, address, length, data_byte, input ready);
  modport sink   (input valid, req_type, op, address, length, data_byte, output ready);
endinterface

interface snfcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [7:0]  spi_byte;
  logic        cs_release;
  logic [15:0] host_value;
  logic        last;

  modport source (output valid, out_kind, spi_byte, cs_release, host_value, last,
                  input ready);
  modport sink   (input valid, out_kind, spi_byte, cs_release, host_value, last,
                  output ready);
endinterface

// File: rtl/core/spi_nor_flash_command_sequencer.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Turns flash operation requests into SPI byte beats, one event per beat.
// ----------------------------------------------------------------------------
// Usage: in_bus carries operation requests, host program bytes and the reply
// byte for every SPI byte sent. out_bus returns SPI bytes to shift out (with
// a chip-select release flag), read data, the device id and a done marker;
// the final result caused by one input beat has last set.
// Erase and program are preceded by write enable and status polling, and
// status is polled again after the command. Programs are split at page
// boundaries, each page repeating the whole sequence.
// The results of an input beat are registered into the result buffer.
// Throughput: one input beat per cycle. Each beat is decoded combinationally
// by the phase state machine and yields up to two results, queued in a
// four-entry result buffer that drains one result per cycle; input is taken
// while at least two entries are free.
// Reset: the sequencer returns to idle and the result buffer empties.
// Stall: when out_bus.ready is low the head result holds, and input stops
// once the buffer cannot hold two more results.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer (
  input logic         clk,
  input logic         rst_n,
  snfcs_in_if.sink    in_bus,
  snfcs_out_if.source out_bus
);
  import snfcs_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [15:0] left_r, left_nxt;
  logic [2:0]  frame_r, frame_nxt;
  logic [7:0]  id_high_r, id_high_nxt;
  logic        await_r, await_nxt;

  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  logic        in_accept, out_accept;
  logic [1:0]  n_res;
  res_t        res0, res1;
  logic [15:0] left_dec;
  logic [23:0] addr_inc;

  assign in_accept  = in_bus.valid && in_bus.ready;
  assign out_accept = out_bus.valid && out_bus.ready;
  assign left_dec   = left_r - 16'd1;
  assign addr_inc   = addr_r + 24'd1;

  always_comb begin
    phase_nxt   = phase_r;
    op_nxt      = op_r;
    addr_nxt    = addr_r;
    left_nxt    = left_r;
    frame_nxt   = frame_r;
    id_high_nxt = id_high_r;
    await_nxt   = await_r;
    n_res       = 2'd0;
    res0        = '0;
    res1        = '0;
    if (in_accept) begin
      case (in_bus.req_type)
        REQ_OP: begin
          if (phase_r == PH_IDLE && in_bus.op <= OP_CHIP) begin
            op_nxt    = in_bus.op;
            addr_nxt  = in_bus.address;
            left_nxt  = in_bus.length;
            frame_nxt = 3'd0;
            n_res     = 2'd1;
            if (in_bus.op == OP_PROG && in_bus.length == 16'd0) begin
              res0 = host_res(KIND_DONE, 16'd0);
            end else if (in_bus.op <= OP_READ) begin
              phase_nxt = PH_HDR;
              await_nxt = 1'b1;
              res0      = hdr_res(in_bus.op, 3'd0, in_bus.address, in_bus.length);
            end else begin
              phase_nxt = PH_WREN;
              await_nxt = 1'b1;
              res0      = spi_res(CMD_WREN, 1'b1);
            end
          end
        end
        REQ_HOST: begin
          if (phase_r == PH_WAIT_HOST && !await_r) begin
            left_nxt  = left_dec;
            addr_nxt  = addr_inc;
            phase_nxt = PH_DATA;
            await_nxt = 1'b1;
            n_res     = 2'd1;
            res0      = spi_res(in_bus.data_byte,
                                left_dec == 16'd0 || addr_inc[PAGE_BITS-1:0] == '0);
          end
        end
        REQ_REPLY: begin
          if (await_r && phase_r != PH_IDLE) begin
            await_nxt = 1'b0;
            unique case (phase_r)
              PH_WREN: begin
                phase_nxt = PH_PRE_CMD;
                await_nxt = 1'b1;
                n_res     = 2'd1;
                res0      = spi_res(CMD_RDSR, 1'b0);
              end
              PH_PRE_CMD: begin
                phase_nxt = PH_PRE_STAT;
                await_nxt = 1'b1;
                n_res     = 2'd1;
                res0      = spi_res(DUMMY_BYTE, 1'b1);
              end
              PH_PRE_STAT: begin
                await_nxt = 1'b1;
                n_res     = 2'd1;
                if ((in_bus.data_byte & STAT_BUSY) != 8'h00) begin
                  phase_nxt = PH_PRE_CMD;
                  res0      = spi_res(CMD_RDSR, 1'b0);
                end else begin
                  phase_nxt = PH_HDR;
                  frame_nxt = 3'd0;
                  res0      = hdr_res(op_r, 3'd0, addr_r, left_r);
                end
              end
              PH_POST_CMD: begin
                phase_nxt = PH_POST_STAT;
                await_nxt = 1'b1;
                n_res     = 2'd1;
                res0      = spi_res(DUMMY_BYTE, 1'b1);
              end
              PH_POST_STAT: begin
                n_res = 2'd1;
                if ((in_bus.data_byte & STAT_BUSY) != 8'h00) begin
                  phase_nxt = PH_POST_CMD;
                  await_nxt = 1'b1;
                  res0      = spi_res(CMD_RDSR, 1'b0);
                end else if (op_r == OP_PROG && left_r != 16'd0) begin
                  // Next page of the program repeats the whole sequence.
                  phase_nxt = PH_WREN;
                  await_nxt = 1'b1;
                  res0      = spi_res(CMD_WREN, 1'b1);
                end else begin
                  phase_nxt = PH_IDLE;
                  res0      = host_res(KIND_DONE, 16'd0);
                end
              end
              PH_HDR: begin
                if (op_r == OP_ID && frame_r == 3'd4) id_high_nxt = in_bus.data_byte;
                if (op_r == OP_ID && frame_r == 3'd5) begin
                  phase_nxt = PH_IDLE;
                  n_res     = 2'd2;
                  res0      = host_res(KIND_ID, {id_high_r, in_bus.data_byte});
                  res1      = host_res(KIND_DONE, 16'd0);
                end else if (frame_r >= last_hdr_frame(op_r)) begin
                  if (op_r == OP_READ) begin
                    n_res = 2'd1;
                    if (left_r == 16'd0) begin
                      phase_nxt = PH_IDLE;
                      res0      = host_res(KIND_DONE, 16'd0);
                    end else begin
                      phase_nxt = PH_READ;
                      await_nxt = 1'b1;
                      res0      = spi_res(DUMMY_BYTE, left_r == 16'd1);
                    end
                  end else if (op_r == OP_PROG) begin
                    phase_nxt = PH_WAIT_HOST;
                  end else begin
                    phase_nxt = PH_POST_CMD;
                    await_nxt = 1'b1;
                    n_res     = 2'd1;
                    res0      = spi_res(CMD_RDSR, 1'b0);
                  end
                end else begin
                  frame_nxt = frame_r + 3'd1;
                  await_nxt = 1'b1;
                  n_res     = 2'd1;
                  res0      = hdr_res(op_r, frame_r + 3'd1, addr_r, left_r);
                end
              end
              PH_READ: begin
                left_nxt = left_dec;
                addr_nxt = addr_inc;
                n_res    = 2'd2;
                res0     = host_res(KIND_READ, {8'h00, in_bus.data_byte});
                if (left_dec == 16'd0) begin
                  phase_nxt = PH_IDLE;
                  res1      = host_res(KIND_DONE, 16'd0);
                end else begin
                  await_nxt = 1'b1;
                  res1      = spi_res(DUMMY_BYTE, left_dec == 16'd1);
                end
              end
              PH_DATA: begin
                if (left_r == 16'd0 || addr_r[PAGE_BITS-1:0] == '0) begin
                  phase_nxt = PH_POST_CMD;
                  await_nxt = 1'b1;
                  n_res     = 2'd1;
                  res0      = spi_res(CMD_RDSR, 1'b0);
                end else begin
                  phase_nxt = PH_WAIT_HOST;
                end
              end
              default: begin
                phase_nxt = phase_r;
              end
            endcase
          end
        end
        default: begin
          n_res = 2'd0;
        end
      endcase
    end
    if (n_res == 2'd1) res0.last = 1'b1;
    if (n_res == 2'd2) res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      op_r      <= '0;
      addr_r    <= '0;
      left_r    <= '0;
      frame_r   <= '0;
      id_high_r <= '0;
      await_r   <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      op_r      <= op_nxt;
      addr_r    <= addr_nxt;
      left_r    <= left_nxt;
      frame_r   <= frame_nxt;
      id_high_r <= id_high_nxt;
      await_r   <= await_nxt;
    end
  end

  // Result buffer.
  always_ff @(posedge clk) begin
    if (n_res != 2'd0) fifo_r[wr_ptr_r] <= res0;
    if (n_res == 2'd2) fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_res);
      if (out_accept) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      cnt_r <= cnt_r + CNT_W'(n_res) - CNT_W'(out_accept);
    end
  end

  assign in_bus.ready       = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign out_bus.valid      = (cnt_r != '0);
  assign out_bus.out_kind   = fifo_r[rd_ptr_r].out_kind;
  assign out_bus.spi_byte   = fifo_r[rd_ptr_r].spi_byte;
  assign out_bus.cs_release = fifo_r[rd_ptr_r].cs_release;
  assign out_bus.host_value = fifo_r[rd_ptr_r].host_value;
  assign out_bus.last       = fifo_r[rd_ptr_r].last;

endmodule

// File: rtl/core/snfcs_checker.sv
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module snfcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  spi_byte,
  input logic        cs_release,
  input logic [15:0] host_value,
  input logic        last
);
  import snfcs_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(spi_byte) &&
                               $stable(cs_release) && $stable(host_value) && $stable(last))
    else $error("result beat changed while stalled");

  // No result is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // Done always closes the results of its input beat.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> last)
    else $error("done beat without last");

  // The device id is always followed by done.
  a_id_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ID |-> !last)
    else $error("device id beat marked last");

  // Only SPI beats carry a byte or a chip-select release.
  a_host_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_SPI |-> spi_byte == 8'h00 && !cs_release)
    else $error("non-SPI beat carries SPI fields");

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_kind   (out_bus.out_kind),
  .spi_byte   (out_bus.spi_byte),
  .cs_release (out_bus.cs_release),
  .host_value (out_bus.host_value),
  .last       (out_bus.last)
);

// File: verif/spi_nor_flash_command_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer testbench
// The bench acts as the flash and as the host. It answers every SPI beat with
// a reply byte, feeds program data, and mixes in stray and illegal beats.
// A built-in sequencer model predicts each result beat, and a scoreboard
// compares every result field against it, in order.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_tb;
  import snfcs_pkg::*;

  // Codes that the block must ignore.
  localparam logic [1:0] REQ_BAD = 2'd3;
  localparam logic [2:0] OP_BAD  = 3'd7;

  typedef struct packed {
    logic [1:0]  req;
    logic [2:0]  op;
    logic [23:0] addr;
    logic [15:0] len;
    logic [7:0]  data;
  } beat_t;

  class flash_result_board;
    phase_t      phase;
    logic [2:0]  cur_op;
    logic [23:0] cur_addr;
    logic [15:0] left;
    logic [2:0]  frame;
    logic [7:0]  id_hi;
    bit          awaiting;
    res_t        pending_results[$];
    res_t        beat_results[$];
    int          errors;

    function new();
      phase    = PH_IDLE;
      cur_op   = '0;
      cur_addr = '0;
      left     = '0;
      frame    = '0;
      id_hi    = '0;
      awaiting = 1'b0;
      errors   = 0;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 100) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function void emit(input logic [1:0] kind, input logic [7:0] b, input logic cs,
                       input logic [15:0] hv);
      res_t r;
      r.out_kind   = kind;
      r.spi_byte   = b;
      r.cs_release = cs;
      r.host_value = hv;
      r.last       = 1'b0;
      beat_results.push_back(r);
    endfunction

    function void send_byte(input logic [7:0] b, input logic cs);
      awaiting = 1'b1;
      emit(KIND_SPI, b, cs, 16'h0000);
    endfunction

    function void close_op();
      phase    = PH_IDLE;
      awaiting = 1'b0;
      emit(KIND_DONE, 8'h00, 1'b0, 16'h0000);
    endfunction

    function logic [2:0] final_frame();
      if (cur_op == OP_ID) return 3'd5;
      if (cur_op == OP_CHIP) return 3'd0;
      return 3'd3;
    endfunction

    function bit page_end();
      return (left == 16'd0) || ((cur_addr % PAGE_BYTES) == 0);
    endfunction

    // Header frames: opcode, three address bytes (zeros for the id command, none
    // for chip erase), then for the id command two dummy bytes that clock the id out.
    function void send_frame();
      logic [7:0] b;
      logic       cs;
      if (frame == 3'd0) begin
        case (cur_op)
          OP_ID:     b = CMD_ID;
          OP_READ:   b = CMD_READ;
          OP_PROG:   b = CMD_PROG;
          OP_SECTOR: b = CMD_SECTOR;
          OP_HALF:   b = CMD_HALF;
          OP_BLOCK:  b = CMD_BLOCK;
          default:   b = CMD_CHIP;
        endcase
      end else if (frame >= 3'd4) begin
        b = DUMMY_BYTE;
      end else if (cur_op == OP_ID) begin
        b = 8'h00;
      end else begin
        case (frame)
          3'd1:    b = cur_addr[23:16];
          3'd2:    b = cur_addr[15:8];
          default: b = cur_addr[7:0];
        endcase
      end
      cs = ((cur_op == OP_ID) && (frame == 3'd5)) ||
           ((cur_op == OP_READ) && (frame == 3'd3) && (left == 16'd0)) ||
           ((cur_op >= OP_SECTOR) && (frame == final_frame()));
      send_byte(b, cs);
    endfunction

    function void on_reply(input logic [7:0] d);
      bit busy;
      busy     = (d & STAT_BUSY) != 8'h00;
      awaiting = 1'b0;
      case (phase)
        PH_WREN: begin
          phase = PH_PRE_CMD;
          send_byte(CMD_RDSR, 1'b0);
        end
        PH_PRE_CMD: begin
          phase = PH_PRE_STAT;
          send_byte(DUMMY_BYTE, 1'b1);
        end
        PH_PRE_STAT: begin
          if (busy) begin
            phase = PH_PRE_CMD;
            send_byte(CMD_RDSR, 1'b0);
          end else begin
            phase = PH_HDR;
            frame = 3'd0;
            send_frame();
          end
        end
        PH_POST_CMD: begin
          phase = PH_POST_STAT;
          send_byte(DUMMY_BYTE, 1'b1);
        end
        PH_POST_STAT: begin
          if (busy) begin
            phase = PH_POST_CMD;
            send_byte(CMD_RDSR, 1'b0);
          end else if (cur_op == OP_PROG && left != 16'd0) begin
            phase = PH_WREN;
            send_byte(CMD_WREN, 1'b1);
          end else begin
            close_op();
          end
        end
        PH_HDR: begin
          if (cur_op == OP_ID && frame == 3'd4) id_hi = d;
          if (cur_op == OP_ID && frame == 3'd5) begin
            emit(KIND_ID, 8'h00, 1'b0, {id_hi, d});
            close_op();
          end else if (frame >= final_frame()) begin
            if (cur_op == OP_READ) begin
              if (left == 16'd0) begin
                close_op();
              end else begin
                phase = PH_READ;
                send_byte(DUMMY_BYTE, left == 16'd1);
              end
            end else if (cur_op == OP_PROG) begin
              phase = PH_WAIT_HOST;
            end else begin
              phase = PH_POST_CMD;
              send_byte(CMD_RDSR, 1'b0);
            end
          end else begin
            frame = frame + 3'd1;
            send_frame();
          end
        end
        PH_READ: begin
          emit(KIND_READ, 8'h00, 1'b0, {8'h00, d});
          left     = left - 16'd1;
          cur_addr = cur_addr + 24'd1;
          if (left == 16'd0) close_op();
          else send_byte(DUMMY_BYTE, left == 16'd1);
        end
        PH_DATA: begin
          if (page_end()) begin
            phase = PH_POST_CMD;
            send_byte(CMD_RDSR, 1'b0);
          end else begin
            phase = PH_WAIT_HOST;
          end
        end
        default: ;
      endcase
    endfunction

    // Predicts the result beats of one accepted input beat.
    function void note_beat(input beat_t b);
      res_t r;
      beat_results.delete();
      case (b.req)
        REQ_OP: begin
          if (phase == PH_IDLE && b.op <= OP_CHIP) begin
            cur_op   = b.op;
            cur_addr = b.addr;
            left     = b.len;
            frame    = 3'd0;
            if (b.op == OP_PROG && b.len == 16'd0) begin
              close_op();
            end else if (b.op <= OP_READ) begin
              phase = PH_HDR;
              send_frame();
            end else begin
              phase = PH_WREN;
              send_byte(CMD_WREN, 1'b1);
            end
          end
        end
        REQ_HOST: begin
          if (phase == PH_WAIT_HOST && !awaiting) begin
            left     = left - 16'd1;
            cur_addr = cur_addr + 24'd1;
            phase    = PH_DATA;
            send_byte(b.data, page_end());
          end
        end
        REQ_REPLY: begin
          if (awaiting && phase != PH_IDLE) on_reply(b.data);
        end
        default: ;
      endcase
      if (beat_results.size() > 0) begin
        r      = beat_results.pop_back();
        r.last = 1'b1;
        beat_results.push_back(r);
      end
      foreach (beat_results[i]) pending_results.push_back(beat_results[i]);
    endfunction

    task check_result(input res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected: kind %0d byte %h value %h",
                         got.out_kind, got.spi_byte, got.host_value));
        return;
      end
      want = pending_results.pop_front();
      if (got.out_kind !== want.out_kind)
        report($sformatf("out_kind %0d, expected %0d", got.out_kind, want.out_kind));
      if (got.spi_byte !== want.spi_byte)
        report($sformatf("spi_byte %h, expected %h", got.spi_byte, want.spi_byte));
      if (got.cs_release !== want.cs_release)
        report($sformatf("cs_release %b, expected %b", got.cs_release, want.cs_release));
      if (got.host_value !== want.host_value)
        report($sformatf("host_value %h, expected %h", got.host_value, want.host_value));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   src_idle_pct;
  int   snk_idle_pct;

  flash_result_board board;

  snfcs_in_if  in_bus ();
  snfcs_out_if out_bus ();

  spi_nor_flash_command_sequencer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1)
      board.check_result({out_bus.out_kind, out_bus.spi_byte, out_bus.cs_release,
                          out_bus.host_value, out_bus.last});
    out_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Plays the flash and the host: answers the outstanding SPI beat, supplies
  // program data, or starts a new operation when the sequencer is idle.
  function automatic beat_t next_beat();
    beat_t b;
    b.req  = REQ_REPLY;
    b.op   = 3'($urandom_range(OP_CHIP));
    b.addr = 24'($urandom);
    b.len  = 16'($urandom);
    b.data = 8'($urandom);
    if (board.awaiting) begin
      b.req = REQ_REPLY;
      if (board.phase == PH_PRE_STAT || board.phase == PH_POST_STAT)
        b.data[0] = ($urandom_range(99) < 30);
    end else if (board.phase == PH_WAIT_HOST) begin
      b.req = REQ_HOST;
    end else begin
      b.req = REQ_OP;
      b.len = 16'($urandom_range(6));
      case ($urandom_range(19))
        0:       b.len = 16'($urandom_range(300, 200));
        1, 2:    b.addr = '1 - 24'($urandom_range(3));
        3, 4, 5: b.addr = (b.addr | 24'(PAGE_BYTES - 1)) - 24'($urandom_range(5));
        default: ;
      endcase
    end
    return b;
  endfunction

  function automatic beat_t stray_beat();
    beat_t b;
    b.req  = 2'($urandom_range(3));
    b.op   = 3'($urandom_range(7));
    b.addr = 24'($urandom);
    b.len  = 16'($urandom);
    b.data = 8'($urandom);
    // An idle sequencer would start on a legal request, so keep it illegal.
    if (board.phase == PH_IDLE && b.req == REQ_OP) b.op = OP_BAD;
    return b;
  endfunction

  task send_beat(input beat_t b, input bit drain);
    if (drain || $urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      if (drain) begin
        do @(posedge clk); while (board.outstanding() != 0);
      end else begin
        repeat ($urandom_range(3, 1)) @(posedge clk);
      end
    end
    in_bus.valid     <= 1'b1;
    in_bus.req_type  <= b.req;
    in_bus.op        <= b.op;
    in_bus.address   <= b.addr;
    in_bus.length    <= b.len;
    in_bus.data_byte <= b.data;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    board.note_beat(b);
  endtask

  // Runs one operation to completion; with intrude set, a request and a host
  // byte arrive while it is busy and must be ignored.
  task run_op(input logic [2:0] op, input logic [23:0] addr, input logic [15:0] len,
              input bit intrude);
    send_beat({REQ_OP, op, addr, len, 8'h00}, 1'b0);
    if (intrude) begin
      send_beat({REQ_OP, OP_CHIP, 24'hFFFFFF, 16'hFFFF, 8'hFF}, 1'b0);
      send_beat({REQ_HOST, OP_ID, 24'h000000, 16'h0000, 8'hFF}, 1'b0);
    end
    while (board.phase != PH_IDLE) send_beat(next_beat(), 1'b0);
  endtask

  initial begin
    int   src_pct [3];
    int   snk_pct [3];
    int   count;
    bit   stray;

    src_pct = '{23, 70, 0};
    snk_pct = '{70, 23, 0};
    board   = new();
    src_idle_pct = src_pct[0];
    snk_idle_pct = snk_pct[0];
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.req_type  <= REQ_OP;
    in_bus.op        <= OP_ID;
    in_bus.address   <= '0;
    in_bus.length    <= '0;
    in_bus.data_byte <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Stray beats on an idle sequencer: none of them may produce a result.
    send_beat({REQ_REPLY, OP_ID, 24'h000000, 16'h0000, 8'hFF}, 1'b0);
    send_beat({REQ_HOST, OP_ID, 24'h000000, 16'h0000, 8'h00}, 1'b0);
    send_beat({REQ_BAD, OP_READ, 24'hFFFFFF, 16'hFFFF, 8'hFF}, 1'b0);
    send_beat({REQ_OP, OP_BAD, 24'hFFFFFF, 16'hFFFF, 8'hFF}, 1'b0);

    run_op(OP_ID, 24'h000000, 16'h0000, 1'b1);
    run_op(OP_READ, 24'hFFFFFE, 16'd3, 1'b0);
    run_op(OP_READ, 24'h123456, 16'd0, 1'b0);
    run_op(OP_READ, 24'h00FFFF, 16'd1, 1'b1);
    run_op(OP_PROG, 24'h000000, 16'd0, 1'b0);
    run_op(OP_PROG, 24'h0000FE, 16'd4, 1'b1);
    run_op(OP_PROG, 24'hFFFFFF, 16'd2, 1'b0);
    run_op(OP_SECTOR, 24'hFFFFFF, 16'hFFFF, 1'b0);
    run_op(OP_HALF, 24'h000000, 16'd0, 1'b0);
    run_op(OP_BLOCK, 24'hABCDEF, 16'd7, 1'b1);
    run_op(OP_CHIP, 24'h5A5A5A, 16'd0, 1'b0);

    for (int p = 0; p < 3; p++) begin
      src_idle_pct = src_pct[p];
      snk_idle_pct = snk_pct[p];
      count = 0;
      stray = 1'b0;
      send_beat(next_beat(), 1'b1);
      while (count < 80) begin
        stray = ($urandom_range(9) == 0);
        if (!stray) count++;
        send_beat(stray ? stray_beat() : next_beat(), $urandom_range(199) == 0);
      end
    end

    in_bus.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
